@@ rtl/core/udec_pkg.sv @@
package udec_pkg;

  // Byte classes for lead bytes.
  localparam logic [7:0] LEAD_TWO_MIN   = 8'h80;
  localparam logic [7:0] LEAD_THREE_MIN = 8'hE0;
  localparam logic [7:0] LEAD_FOUR_MIN  = 8'hF0;

  // Payload masks for lead and continuation bytes.
  localparam logic [7:0] MASK_TWO   = 8'h1F;
  localparam logic [7:0] MASK_THREE = 8'h0F;
  localparam logic [7:0] MASK_FOUR  = 8'h07;
  localparam logic [7:0] MASK_CONT  = 8'h3F;

  localparam int unsigned CP_W  = 21;
  localparam int unsigned LEN_W = 3;

  // Announced sequence lengths.
  localparam logic [LEN_W-1:0] LEN_ONE   = 3'd1;
  localparam logic [LEN_W-1:0] LEN_TWO   = 3'd2;
  localparam logic [LEN_W-1:0] LEN_THREE = 3'd3;
  localparam logic [LEN_W-1:0] LEN_FOUR  = 3'd4;

  // One input byte.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_text;
  } in_item_t;

  // One decoded character.
  typedef struct packed {
    logic [CP_W-1:0]  code_point;
    logic [LEN_W-1:0] byte_count;
    logic             truncated;
    logic             last_char;
  } out_item_t;

  // Result of one decode step, handed to the output register.
  typedef struct packed {
    logic      valid;
    out_item_t item;
  } step_res_t;

endpackage

@@ rtl/core/udec_if.sv @@
// Input byte channel.
interface udec_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_text;

  modport source (output valid, output data_byte, output end_of_text, input ready);
  modport sink (input valid, input data_byte, input end_of_text, output ready);
endinterface

// Decoded character channel.
interface udec_out_if;
  logic        valid;
  logic        ready;
  logic [20:0] code_point;
  logic [2:0]  byte_count;
  logic        truncated;
  logic        last_char;

  modport source (output valid, output code_point, output byte_count,
                  output truncated, output last_char, input ready);
  modport sink (input valid, input code_point, input byte_count,
                input truncated, input last_char, output ready);
endinterface

@@ rtl/core/udec_step.sv @@
module udec_step (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  udec_pkg::in_item_t  in_item,
  output udec_pkg::step_res_t res
);
  import udec_pkg::*;

  logic [CP_W-1:0]  partial_r,  partial_nxt;
  logic [1:0]       remain_r,   remain_nxt;
  logic [LEN_W-1:0] seq_len_r,  seq_len_nxt;

  logic [7:0]       b;
  logic             eot;
  logic [1:0]       remain_dec;
  logic [CP_W-1:0]  cont_bits;
  logic [CP_W-1:0]  merged;
  logic [CP_W-1:0]  lead_val;
  logic [LEN_W-1:0] lead_len;

  assign b   = in_item.data_byte;
  assign eot = in_item.end_of_text;

  // Lead byte classification: stray continuation bytes count as 2-byte leads.
  always_comb begin
    priority if (b < LEAD_THREE_MIN) begin
      lead_val = {10'd0, b[4:0] & MASK_TWO[4:0], 6'd0};
      lead_len = LEN_TWO;
    end else if (b < LEAD_FOUR_MIN) begin
      lead_val = {5'd0, b[3:0] & MASK_THREE[3:0], 12'd0};
      lead_len = LEN_THREE;
    end else begin
      lead_val = {b[2:0] & MASK_FOUR[2:0], 18'd0};
      lead_len = LEN_FOUR;
    end
  end

  // Continuation bytes land at their final bit position.
  assign remain_dec = remain_r - 2'd1;
  always_comb begin
    unique case (remain_dec)
      2'd0:    cont_bits = {15'd0, b[5:0] & MASK_CONT[5:0]};
      2'd1:    cont_bits = {9'd0, b[5:0] & MASK_CONT[5:0], 6'd0};
      2'd2:    cont_bits = {3'd0, b[5:0] & MASK_CONT[5:0], 12'd0};
      default: cont_bits = {b[2:0] & MASK_FOUR[2:0], 18'd0};
    endcase
  end
  assign merged = partial_r | cont_bits;

  // Next state and result for the byte on the input.
  always_comb begin
    partial_nxt = partial_r;
    remain_nxt  = remain_r;
    seq_len_nxt = seq_len_r;
    res         = '0;
    if (remain_r == 2'd0) begin
      if (b < LEAD_TWO_MIN) begin
        res.valid           = 1'b1;
        res.item.code_point = {13'd0, b};
        res.item.byte_count = LEN_ONE;
        res.item.last_char  = eot;
        partial_nxt = '0;
        seq_len_nxt = '0;
      end else if (eot) begin
        res.valid           = 1'b1;
        res.item.code_point = lead_val;
        res.item.byte_count = lead_len;
        res.item.truncated  = 1'b1;
        res.item.last_char  = 1'b1;
        partial_nxt = '0;
        seq_len_nxt = '0;
      end else begin
        partial_nxt = lead_val;
        seq_len_nxt = lead_len;
        remain_nxt  = lead_len[1:0] - 2'd1;
      end
    end else begin
      if (remain_dec == 2'd0 || eot) begin
        res.valid           = 1'b1;
        res.item.code_point = merged;
        res.item.byte_count = seq_len_r;
        res.item.truncated  = (remain_dec != 2'd0);
        res.item.last_char  = eot;
        partial_nxt = '0;
        remain_nxt  = '0;
        seq_len_nxt = '0;
      end else begin
        partial_nxt = merged;
        remain_nxt  = remain_dec;
      end
    end
  end

  // Decoder state advances on every input transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      partial_r <= '0;
      remain_r  <= '0;
      seq_len_r <= '0;
    end else if (accept) begin
      partial_r <= partial_nxt;
      remain_r  <= remain_nxt;
      seq_len_r <= seq_len_nxt;
    end
  end

endmodule

@@ rtl/core/udec_outreg.sv @@
module udec_outreg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  udec_pkg::step_res_t res,
  input  logic                out_ready,
  output logic                out_valid,
  output logic                can_accept,
  output udec_pkg::out_item_t out_item
);
  import udec_pkg::*;

  logic      valid_r;
  out_item_t item_r;

  // A new byte may enter when no result is held, or when the held result leaves in the same cycle.
  assign can_accept = !valid_r || out_ready;
  assign out_valid  = valid_r;
  assign out_item   = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (accept) begin
      valid_r <= res.valid;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  // Result payload loads only when a character is produced.
  always_ff @(posedge clk) begin
    if (accept && res.valid) begin
      item_r <= res.item;
    end
  end

endmodule

@@ rtl/core/utf8_stream_decoder.sv @@
// A character is presented in the cycle after the transfer of the byte that completes it.
// Throughput: one byte per cycle; the single decode step plus one output register set the rate.
// A held result stalls input only while out_ready is low.
// Reset (rst_n low, synchronous) clears the partial code point, the remaining
// byte count and the output valid flag.
module utf8_stream_decoder (
  input logic        clk,
  input logic        rst_n,
  udec_in_if.sink    in_ch,
  udec_out_if.source out_ch
);
  import udec_pkg::*;

  logic      accept;
  logic      can_accept;
  in_item_t  in_item;
  step_res_t res;
  out_item_t out_item;

  assign in_ch.ready = can_accept;
  assign accept      = in_ch.valid && can_accept;
  assign in_item.data_byte   = in_ch.data_byte;
  assign in_item.end_of_text = in_ch.end_of_text;

  // Byte decode and code point accumulation.
  udec_step u_step (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_item (in_item),
    .res     (res)
  );

  // Result register toward the output channel.
  udec_outreg u_outreg (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .res        (res),
    .out_ready  (out_ch.ready),
    .out_valid  (out_ch.valid),
    .can_accept (can_accept),
    .out_item   (out_item)
  );

  assign out_ch.code_point = out_item.code_point;
  assign out_ch.byte_count = out_item.byte_count;
  assign out_ch.truncated  = out_item.truncated;
  assign out_ch.last_char  = out_item.last_char;

endmodule

@@ verif/utf8_stream_decoder_tb.sv @@
module utf8_stream_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import udec_pkg::*;

  localparam int unsigned RANDOM_BYTES = 1950;
  localparam int unsigned DRAIN_POINT  = 900;
  localparam int unsigned HOLD_POINT   = 400;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned REPORT_MAX   = 10;

  logic clk = 1'b0;
  logic rst_n;

  udec_in_if  in_ch ();
  udec_out_if out_ch ();

  utf8_stream_decoder dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Bytes waiting to be offered, and characters the decoder still owes us.
  in_item_t  byte_queue[$];
  out_item_t char_expected[$];

  int unsigned errors = 0;
  int unsigned bytes_accepted = 0;

  // Shadow decoder state.
  logic [CP_W-1:0]  cp_acc = '0;
  logic [1:0]       cont_left = '0;
  logic [LEN_W-1:0] seq_len = '0;

  // Decode one accepted byte; returns 1 when a character comes out of it.
  function automatic bit decode_byte(input in_item_t item, output out_item_t res);
    logic [7:0]      b;
    logic [CP_W-1:0] piece;
    bit              emit;
    b = item.data_byte;
    emit = 1'b0;
    res = '0;
    if (cont_left == 2'd0) begin
      if (b < LEAD_TWO_MIN) begin
        res = '{code_point: CP_W'(b), byte_count: LEN_ONE, truncated: 1'b0,
                last_char: item.end_of_text};
        emit = 1'b1;
      end else begin
        // Stray continuation bytes fall into the two-byte class on purpose.
        if (b < LEAD_THREE_MIN) begin
          cp_acc  = CP_W'(b & MASK_TWO) << 6;
          seq_len = LEN_TWO;
        end else if (b < LEAD_FOUR_MIN) begin
          cp_acc  = CP_W'(b & MASK_THREE) << 12;
          seq_len = LEN_THREE;
        end else begin
          cp_acc  = CP_W'(b & MASK_FOUR) << 18;
          seq_len = LEN_FOUR;
        end
        cont_left = 2'(seq_len - 3'd1);
        if (item.end_of_text) begin
          res = '{code_point: cp_acc, byte_count: seq_len, truncated: 1'b1,
                  last_char: 1'b1};
          emit = 1'b1;
        end
      end
    end else begin
      cont_left = cont_left - 2'd1;
      piece = CP_W'(b & MASK_CONT) << (6 * cont_left);
      cp_acc = cp_acc | piece;
      if (cont_left == 2'd0) begin
        res = '{code_point: cp_acc, byte_count: seq_len, truncated: 1'b0,
                last_char: item.end_of_text};
        emit = 1'b1;
      end else if (item.end_of_text) begin
        // Missing continuation bytes count as zero.
        res = '{code_point: cp_acc, byte_count: seq_len, truncated: 1'b1,
                last_char: 1'b1};
        emit = 1'b1;
      end
    end
    if (emit) begin
      cp_acc    = '0;
      cont_left = '0;
      seq_len   = '0;
    end
    return emit;
  endfunction

  // Sender: bursts of random length separated by random gaps.
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned gap_pick;
  logic        next_valid;
  in_item_t    next_item;
  in_item_t    taken_item;
  out_item_t   predicted;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      next_valid = in_ch.valid;
      if (in_ch.valid && in_ch.ready) begin
        taken_item = '{data_byte: in_ch.data_byte, end_of_text: in_ch.end_of_text};
        if (decode_byte(taken_item, predicted)) begin
          char_expected.push_back(predicted);
        end
        bytes_accepted <= bytes_accepted + 1;
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (gap_left > 0) begin
          gap_left = gap_left - 1;
        end else if (byte_queue.size() > 0) begin
          next_item = byte_queue.pop_front();
          in_ch.data_byte   <= next_item.data_byte;
          in_ch.end_of_text <= next_item.end_of_text;
          next_valid = 1'b1;
          if (burst_left > 0) begin
            burst_left = burst_left - 1;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_pick = $urandom_range(0, 9);
            if (gap_pick < 4) begin
              gap_left = 0;
            end else if (gap_pick < 8) begin
              gap_left = $urandom_range(1, 3);
            end else begin
              gap_left = $urandom_range(4, 20);
            end
          end
        end
      end
      in_ch.valid <= next_valid;
    end
  end

  // Receiver: checks each transfer and stalls on a pattern that changes mode.
  int unsigned rx_mode = 0;
  int unsigned rx_mode_left = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  logic        next_ready;
  out_item_t   got_char;
  out_item_t   want_char;

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got_char = '{code_point: out_ch.code_point, byte_count: out_ch.byte_count,
                   truncated: out_ch.truncated, last_char: out_ch.last_char};
      if (char_expected.size() == 0) begin
        errors = errors + 1;
        if (errors <= REPORT_MAX) begin
          $display("unexpected character: cp=%h count=%0d trunc=%b last=%b",
                   got_char.code_point, got_char.byte_count,
                   got_char.truncated, got_char.last_char);
        end
      end else begin
        want_char = char_expected.pop_front();
        if (got_char !== want_char) begin
          errors = errors + 1;
          if (errors <= REPORT_MAX) begin
            $display("character mismatch: cp=%h/%h count=%0d/%0d trunc=%b/%b last=%b/%b",
                     want_char.code_point, got_char.code_point,
                     want_char.byte_count, got_char.byte_count,
                     want_char.truncated, got_char.truncated,
                     want_char.last_char, got_char.last_char);
          end
        end
      end
    end

    // One long hold-off so the decoder backs up into its input.
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      next_ready = 1'b0;
    end else if (!hold_done && bytes_accepted >= HOLD_POINT) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      next_ready = 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_mode_left = $urandom_range(20, 120);
      end else begin
        rx_mode_left = rx_mode_left - 1;
      end
      case (rx_mode)
        0: next_ready = 1'b1;
        1: next_ready = ($urandom_range(0, 1) == 0);
        2: next_ready = ($urandom_range(0, 9) != 0);
        default: next_ready = ($urandom_range(0, 4) == 0);
      endcase
    end
    out_ch.ready <= rst_n ? next_ready : 1'b0;
  end

  // Watchdog.
  int unsigned cycle_count = 0;

  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("utf8_stream_decoder_tb: done, errors");
      $finish;
    end
  end

  task automatic queue_byte(input logic [7:0] b, input logic eot);
    byte_queue.push_back('{data_byte: b, end_of_text: eot});
  endtask

  // Block until every byte has been taken and every character has arrived.
  // The falling edge sees the queues and valid after all clocked updates.
  task automatic wait_drained();
    while (byte_queue.size() != 0 || in_ch.valid || char_expected.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // Builds a byte that continues a sequence; now and then a malformed one.
  function automatic logic [7:0] cont_byte();
    if ($urandom_range(0, 7) == 0) begin
      return 8'($urandom_range(0, 255));
    end
    return 8'h80 | 8'($urandom_range(0, 63));
  endfunction

  int unsigned queued_random = 0;
  bit          drain_done = 1'b0;
  int unsigned n_chars;
  int unsigned kind;
  int unsigned drop;
  logic [7:0]  text[$];

  initial begin
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.data_byte   = '0;
    in_ch.end_of_text = 1'b0;
    out_ch.ready      = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: extremes of ASCII, every sequence length, stray continuation
    // bytes as leads, leads from F8 up, and strings that end mid-sequence.
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h7F, 1'b1);
    queue_byte(8'hC3, 1'b0);
    queue_byte(8'hA9, 1'b0);
    queue_byte(8'h80, 1'b0);
    queue_byte(8'hBF, 1'b0);
    queue_byte(8'hE2, 1'b0);
    queue_byte(8'h82, 1'b0);
    queue_byte(8'hAC, 1'b0);
    queue_byte(8'hF0, 1'b0);
    queue_byte(8'h9F, 1'b0);
    queue_byte(8'h98, 1'b0);
    queue_byte(8'h80, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'hFF, 1'b1);
    queue_byte(8'hE2, 1'b0);
    queue_byte(8'h82, 1'b1);
    queue_byte(8'hC3, 1'b1);
    queue_byte(8'hDF, 1'b0);
    queue_byte(8'hBF, 1'b1);
    wait_drained();

    // Random strings, mostly well formed, with noise bytes and cut-off ends.
    while (queued_random < RANDOM_BYTES) begin
      if (!drain_done && queued_random >= DRAIN_POINT) begin
        wait_drained();
        drain_done = 1'b1;
      end
      text.delete();
      n_chars = $urandom_range(1, 12);
      for (int c = 0; c < n_chars; c++) begin
        kind = $urandom_range(0, 19);
        if (kind < 6) begin
          text.push_back(8'($urandom_range(0, 127)));
        end else if (kind < 10) begin
          text.push_back(8'hC0 | 8'($urandom_range(0, 31)));
          text.push_back(cont_byte());
        end else if (kind < 14) begin
          text.push_back(8'hE0 | 8'($urandom_range(0, 15)));
          repeat (2) text.push_back(cont_byte());
        end else if (kind < 17) begin
          text.push_back(8'hF0 | 8'($urandom_range(0, 15)));
          repeat (3) text.push_back(cont_byte());
        end else begin
          text.push_back(8'($urandom_range(0, 255)));
        end
      end
      if (text.size() > 1 && $urandom_range(0, 6) == 0) begin
        drop = $urandom_range(1, (text.size() > 4) ? 3 : text.size() - 1);
        repeat (drop) void'(text.pop_back());
      end
      foreach (text[i]) begin
        queue_byte(text[i], i == text.size() - 1);
      end
      queued_random = queued_random + text.size();
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("utf8_stream_decoder_tb: done, clean");
    end else begin
      $display("utf8_stream_decoder_tb: done, errors");
    end
    $finish;
  end

endmodule
